/* rtl/rrss_pkg.sv */
`timescale 1ns / 1ps

package rrss_pkg;

	localparam int MAX_TASKS = 15;
	localparam int SLOTS     = 16;
	localparam int TASK_W    = 4;
	localparam int PTR_W     = TASK_W + 1;
	localparam int CTR_W     = 8;

	localparam logic [TASK_W-1:0] IDLE_TASK = '0;
	localparam logic [CTR_W-1:0]  CTR_READY = CTR_W'(1);

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SET  = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [CTR_W-1:0] counter_value;
	} in_word_t;

	typedef struct packed {
		logic [TASK_W-1:0] running_task;
		logic              first_start;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DECR,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DEC
	} bank_cmd_t;

	typedef struct packed {
		bank_cmd_t         cmd;
		logic [TASK_W-1:0] idx;
		logic [CTR_W-1:0]  value;
	} bank_op_t;

endpackage

/* rtl/round_robin_sleep_scheduler.sv */
`timescale 1ns / 1ps

// Round-robin scheduler with per-task sleep counters: entry 0 is idle, tasks
// 1..task_count are user tasks. A tick word walks from the task after the last
// one run, decrementing sleepers, picks the first ready task (counter 1) and
// then decrements the sleepers it did not pass; with none ready, idle runs. A
// set word loads the current task's counter. One counter entry is visited per
// cycle through the single counter-bank port; a tick walks at most a full wrap
// of the n effective tasks (zero counting as one) before it finishes its
// decrement pass, and both word kinds wait while the output register stays
// full; in_ready is low until the word is done.
// A finished result sits in the output register while the next word is taken.
module round_robin_sleep_scheduler import rrss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TASK_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_data
);

	state_t            state_q, state_d;
	logic [TASK_W-1:0] task_count_q;
	logic [TASK_W-1:0] cur_q, last_q;
	logic [TASK_W-1:0] walk_q, walk_d, stop_q, stop_d;
	logic [PTR_W-1:0]  ptr_q, ptr_d;
	logic [TASK_W-1:0] res_idx_q, res_idx_d, res_last_q, res_last_d;
	logic              tick_q, tick_d;
	logic [SLOTS-1:0]  started_q;
	logic              out_valid_q;
	out_word_t         out_q;

	logic [TASK_W-1:0] n;
	logic [TASK_W-1:0] cur_init, last_init;
	logic [TASK_W-1:0] walk_nxt, decr_idx;
	logic              fin_load;
	logic              first;
	bank_op_t          bank_op;
	logic [CTR_W-1:0]  bank_rd;

	rrss_wait_bank u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (bank_op),
		.rd_data (bank_rd)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// effective task count: zero acts as one, capped at MAX_TASKS
	always_comb begin
		if (task_count_q == '0) begin
			n = TASK_W'(1);
		end else if (task_count_q > TASK_W'(MAX_TASKS)) begin
			n = TASK_W'(MAX_TASKS);
		end else begin
			n = task_count_q;
		end
	end

	// walk start after clamping to a possibly shrunk task count
	always_comb begin
		cur_init  = (cur_q > n) ? n : cur_q;
		last_init = (last_q > n) ? n : last_q;
		if (cur_init == '0 && last_init != '0) begin
			cur_init = last_init;
		end
		if (last_init == '0) begin
			last_init = TASK_W'(1);
		end
	end

	assign walk_nxt = (walk_q == n) ? TASK_W'(1) : walk_q + TASK_W'(1);
	// decrement pass wraps through idle
	assign decr_idx = (ptr_q > {1'b0, n}) ? IDLE_TASK : ptr_q[TASK_W-1:0];
	assign first    = tick_q & ~started_q[res_idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		walk_d        = walk_q;
		stop_d        = stop_q;
		ptr_d         = ptr_q;
		res_idx_d     = res_idx_q;
		res_last_d    = res_last_q;
		tick_d        = tick_q;
		fin_load      = 1'b0;
		bank_op.cmd   = CMD_NONE;
		bank_op.idx   = walk_nxt;
		bank_op.value = in_data.counter_value;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.kind == KIND_SET) begin
						bank_op.cmd = CMD_LOAD;
						bank_op.idx = cur_q;
						res_idx_d   = cur_q;
						res_last_d  = last_q;
						tick_d      = 1'b0;
						state_d     = ST_FIN;
					end else begin
						walk_d  = cur_init;
						stop_d  = last_init;
						tick_d  = 1'b1;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				bank_op.cmd = CMD_DEC;
				bank_op.idx = walk_nxt;
				if (bank_rd == CTR_READY) begin
					res_idx_d  = walk_nxt;
					res_last_d = walk_nxt;
					ptr_d      = {1'b0, walk_nxt} + PTR_W'(1);
					state_d    = ST_DECR;
				end else if (walk_nxt == stop_q) begin
					res_idx_d  = IDLE_TASK;
					res_last_d = stop_q;
					state_d    = ST_FIN;
				end else begin
					walk_d = walk_nxt;
				end
			end
			ST_DECR: begin
				if (ptr_q == {1'b0, stop_q}) begin
					state_d = ST_FIN;
				end else begin
					bank_op.cmd = CMD_DEC;
					bank_op.idx = decr_idx;
					ptr_d       = {1'b0, decr_idx} + PTR_W'(1);
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					fin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= TASK_W'(1);
			cur_q        <= IDLE_TASK;
			last_q       <= IDLE_TASK;
			started_q    <= SLOTS'(1);
			out_valid_q  <= 1'b0;
			tick_q       <= 1'b0;
		end else begin
			tick_q <= tick_d;
			if (cfg_valid && cfg_ready) begin
				task_count_q <= cfg_data;
			end
			if (fin_load) begin
				cur_q       <= res_idx_q;
				last_q      <= res_last_q;
				out_valid_q <= 1'b1;
				if (tick_q) begin
					started_q[res_idx_q] <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		walk_q     <= walk_d;
		stop_q     <= stop_d;
		ptr_q      <= ptr_d;
		res_idx_q  <= res_idx_d;
		res_last_q <= res_last_d;
		if (fin_load) begin
			out_q.running_task <= res_idx_q;
			out_q.first_start  <= first;
		end
	end

`ifndef ASSERT_OFF
	a_idle_never_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.first_start |-> out_q.running_task != IDLE_TASK)
		else $error("idle reported as first start");

	a_first_marks_started: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.first_start |-> started_q[out_q.running_task])
		else $error("first start without started flag");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a word while busy");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECR |-> ptr_q <= PTR_W'(SLOTS))
		else $error("decrement pointer out of range");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_valid_q && !out_ready |=> state_q == ST_FIN)
		else $error("result dropped while output held");
`endif

endmodule

/* rtl/rrss_wait_bank.sv */
`timescale 1ns / 1ps

module rrss_wait_bank import rrss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bank_op_t         op,
	output logic [CTR_W-1:0] rd_data
);

	logic [CTR_W-1:0] wc_q [SLOTS];

	// read returns the value before this cycle's update
	assign rd_data = wc_q[op.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				wc_q[i] <= CTR_READY;
			end
		end else begin
			case (op.cmd)
				CMD_LOAD: wc_q[op.idx] <= op.value;
				// only sleeping counters move; ready and blocked stay put
				CMD_DEC: begin
					if (wc_q[op.idx] > CTR_READY) begin
						wc_q[op.idx] <= wc_q[op.idx] - CTR_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule
